[rtl/core/poa_pkg.sv]
// ---------------------------------------------------------------------------
// poa_pkg - shared types and constants of the Path ORAM access unit
// Tree geometry, stash sizing, status codes, controller states and the
// command/status structs passed between controller and datapath.
// ---------------------------------------------------------------------------
package poa_pkg;

  localparam int TreeHeight  = 10;
  localparam int BucketSlots = 4;
  localparam int StashDepth  = 33;
  localparam int PayloadBits = 64;

  localparam int IdBits       = 10;
  localparam int LeafBits     = 10;
  localparam int DataBits     = 64;
  localparam int StatusBits   = 3;

  localparam int LevelCount   = TreeHeight + 1;
  localparam int NodeBits     = TreeHeight + 1;
  localparam int NodeCount    = 1 << NodeBits;
  localparam int TreeSlots    = NodeCount * BucketSlots;
  localparam int TreeAddrBits = $clog2(TreeSlots);
  localparam int SlotCntBits  = $clog2(BucketSlots + 1);
  localparam int LevelBits    = $clog2(LevelCount + 1);
  localparam int StashIdxBits = $clog2(StashDepth);
  localparam int StashCntBits = $clog2(StashDepth + 1);
  localparam int PathCntBits  = $clog2(LevelCount * BucketSlots + 1);
  localparam int CmpBits      = ((PathCntBits > StashCntBits) ? PathCntBits : StashCntBits) + 1;

  // leaf bits above the tree height are dropped
  localparam int LeafKeep = (TreeHeight < LeafBits) ? TreeHeight : LeafBits;
  localparam logic [LeafBits-1:0] LeafMask = LeafBits'((64'd1 << LeafKeep) - 64'd1);

  typedef enum logic [StatusBits-1:0] {
    ResHit      = 3'd0,
    ResReadMiss = 3'd1,
    ResInserted = 3'd2,
    ResDropped  = 3'd3,
    ResOverflow = 3'd4
  } res_status_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StCountRd,
    StCountChk,
    StCountEval,
    StLoadRd,
    StLoadWr,
    StLookRd,
    StLookChk,
    StInsert,
    StEvictScan,
    StPad,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic                    valid;
    logic [IdBits-1:0]       id;
    logic [LeafBits-1:0]     leaf;
    logic [PayloadBits-1:0]  data;
  } tree_ent_t;

  typedef struct packed {
    logic [IdBits-1:0]       id;
    logic [LeafBits-1:0]     leaf;
    logic [PayloadBits-1:0]  data;
  } stash_ent_t;

  typedef struct packed {
    logic                    start;
    logic                    clr;
    logic [TreeAddrBits-1:0] clr_addr;
    logic [LevelBits-1:0]    level;
    logic [SlotCntBits-1:0]  slot;
    logic [StashIdxBits-1:0] rd_idx;
    logic [StashIdxBits-1:0] chk_idx;
    logic                    path_rd;
    logic                    path_count;
    logic                    path_load;
    logic                    stash_rd;
    logic                    look_chk;
    logic                    insert;
    logic                    evict_chk;
    logic                    level_start;
    logic                    pad;
    logic                    abort;
    logic                    finish;
  } dp_cmd_t;

  typedef struct packed {
    logic fits;
    logic out_busy;
  } dp_stat_t;

endpackage

[rtl/core/poa_ctrl.sv]
// ---------------------------------------------------------------------------
// poa_ctrl - access sequencer
// Walks the clearing pass, path count, path load, stash lookup, insert and
// per-level eviction, issuing one datapath command per cycle.
// ---------------------------------------------------------------------------
module poa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  poa_pkg::dp_stat_t stat_i,
  output poa_pkg::dp_cmd_t  cmd_o
);

  poa_pkg::ctrl_state_e state_q, state_d;
  logic [poa_pkg::LevelBits-1:0]    level_q, level_d;
  logic [poa_pkg::SlotCntBits-1:0]  slot_q, slot_d;
  logic [poa_pkg::StashCntBits-1:0] sidx_q, sidx_d;
  logic [poa_pkg::TreeAddrBits-1:0] clr_q, clr_d;

  logic last_slot, last_level;

  assign last_slot  = (slot_q == poa_pkg::SlotCntBits'(poa_pkg::BucketSlots - 1));
  assign last_level = (level_q == poa_pkg::LevelBits'(poa_pkg::TreeHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= poa_pkg::StClear;
      level_q <= '0;
      slot_q  <= '0;
      sidx_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      slot_q  <= slot_d;
      sidx_q  <= sidx_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    slot_d  = slot_q;
    sidx_d  = sidx_q;
    clr_d   = clr_q;
    s_axis_tready = 1'b0;

    cmd_o          = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.level    = level_q;
    cmd_o.slot     = slot_q;
    cmd_o.rd_idx   = sidx_q[poa_pkg::StashIdxBits-1:0];
    cmd_o.chk_idx  = sidx_q[poa_pkg::StashIdxBits-1:0];

    unique case (state_q)
      poa_pkg::StClear: begin
        cmd_o.clr = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == poa_pkg::TreeAddrBits'(poa_pkg::TreeSlots - 1)) begin
          state_d = poa_pkg::StIdle;
        end
      end
      poa_pkg::StIdle: begin
        s_axis_tready = !stat_i.out_busy;
        if (s_axis_tvalid && !stat_i.out_busy) begin
          cmd_o.start = 1'b1;
          level_d = '0;
          slot_d  = '0;
          state_d = poa_pkg::StCountRd;
        end
      end
      poa_pkg::StCountRd: begin
        cmd_o.path_rd = 1'b1;
        state_d = poa_pkg::StCountChk;
      end
      poa_pkg::StCountChk: begin
        cmd_o.path_count = 1'b1;
        state_d = poa_pkg::StCountRd;
        if (last_slot) begin
          slot_d = '0;
          if (last_level) begin
            state_d = poa_pkg::StCountEval;
          end else begin
            level_d = level_q + 1'b1;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      poa_pkg::StCountEval: begin
        level_d = '0;
        slot_d  = '0;
        if (stat_i.fits) begin
          state_d = poa_pkg::StLoadRd;
        end else begin
          cmd_o.abort = 1'b1;
          state_d = poa_pkg::StIdle;
        end
      end
      poa_pkg::StLoadRd: begin
        cmd_o.path_rd = 1'b1;
        state_d = poa_pkg::StLoadWr;
      end
      poa_pkg::StLoadWr: begin
        cmd_o.path_load = 1'b1;
        state_d = poa_pkg::StLoadRd;
        if (last_slot) begin
          slot_d = '0;
          if (last_level) begin
            sidx_d  = '0;
            state_d = poa_pkg::StLookRd;
          end else begin
            level_d = level_q + 1'b1;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      poa_pkg::StLookRd: begin
        cmd_o.stash_rd = 1'b1;
        state_d = poa_pkg::StLookChk;
      end
      poa_pkg::StLookChk: begin
        cmd_o.look_chk = 1'b1;
        if (sidx_q == poa_pkg::StashCntBits'(poa_pkg::StashDepth - 1)) begin
          state_d = poa_pkg::StInsert;
        end else begin
          sidx_d  = sidx_q + 1'b1;
          state_d = poa_pkg::StLookRd;
        end
      end
      poa_pkg::StInsert: begin
        cmd_o.insert      = 1'b1;
        cmd_o.level_start = 1'b1;
        level_d = '0;
        sidx_d  = '0;
        state_d = poa_pkg::StEvictScan;
      end
      poa_pkg::StEvictScan: begin
        // read of entry k overlaps the check of entry k-1
        cmd_o.stash_rd  = (sidx_q < poa_pkg::StashCntBits'(poa_pkg::StashDepth));
        cmd_o.evict_chk = (sidx_q != '0);
        cmd_o.chk_idx   = poa_pkg::StashIdxBits'(sidx_q - 1'b1);
        sidx_d = sidx_q + 1'b1;
        if (sidx_q == poa_pkg::StashCntBits'(poa_pkg::StashDepth)) begin
          slot_d  = '0;
          state_d = poa_pkg::StPad;
        end
      end
      poa_pkg::StPad: begin
        cmd_o.pad = 1'b1;
        if (last_slot) begin
          slot_d = '0;
          if (last_level) begin
            state_d = poa_pkg::StDone;
          end else begin
            cmd_o.level_start = 1'b1;
            level_d = level_q + 1'b1;
            sidx_d  = '0;
            state_d = poa_pkg::StEvictScan;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      poa_pkg::StDone: begin
        cmd_o.finish = 1'b1;
        state_d = poa_pkg::StIdle;
      end
      default: begin
        state_d = poa_pkg::StIdle;
      end
    endcase
  end

endmodule

[rtl/core/poa_datapath.sv]
// ---------------------------------------------------------------------------
// poa_datapath - tree and stash storage with access datapath
// Holds the bucket tree memory, the stash memory and its valid bits, the
// request and result registers, and the output register.
// ---------------------------------------------------------------------------
module poa_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  poa_pkg::dp_cmd_t                 cmd_i,
  output poa_pkg::dp_stat_t                stat_o,
  input  logic                             action_i,
  input  logic [poa_pkg::IdBits-1:0]       req_id_i,
  input  logic [poa_pkg::LeafBits-1:0]     current_leaf_i,
  input  logic [poa_pkg::LeafBits-1:0]     fresh_leaf_i,
  input  logic [poa_pkg::DataBits-1:0]     write_data_i,
  input  logic                             m_tready_i,
  output logic                             m_tvalid_o,
  output logic [poa_pkg::IdBits-1:0]       out_req_id_o,
  output logic [poa_pkg::LeafBits-1:0]     out_leaf_o,
  output logic [poa_pkg::DataBits-1:0]     out_data_o,
  output logic [poa_pkg::StatusBits-1:0]   status_o
);

  function automatic logic [poa_pkg::TreeAddrBits-1:0] path_addr(
    input logic [poa_pkg::LeafBits-1:0]    leaf,
    input logic [poa_pkg::LevelBits-1:0]   level,
    input logic [poa_pkg::SlotCntBits-1:0] slot
  );
    logic [poa_pkg::NodeBits-1:0] node;
    node = {1'b1, poa_pkg::TreeHeight'(leaf)} >> level;
    return poa_pkg::TreeAddrBits'(node) * poa_pkg::TreeAddrBits'(poa_pkg::BucketSlots)
         + poa_pkg::TreeAddrBits'(slot);
  endfunction

  // request
  logic                               wr_q;
  logic [poa_pkg::IdBits-1:0]         id_q;
  logic [poa_pkg::LeafBits-1:0]       cur_q, fresh_q;
  logic [poa_pkg::PayloadBits-1:0]    wdata_q;

  // result
  logic                               found_q, found_d;
  logic [poa_pkg::LeafBits-1:0]       res_leaf_q, res_leaf_d;
  logic [poa_pkg::PayloadBits-1:0]    res_data_q, res_data_d;
  poa_pkg::res_status_e               res_status_q, res_status_d;
  logic                               out_valid_q, out_valid_d;

  // counters
  logic [poa_pkg::PathCntBits-1:0]    need_q, need_d;
  logic [poa_pkg::StashCntBits-1:0]   occ_q, occ_d;
  logic [poa_pkg::SlotCntBits-1:0]    used_q, used_d;
  logic [poa_pkg::StashDepth-1:0]     sv_q, sv_d;

  // memories
  poa_pkg::tree_ent_t  tree_mem [poa_pkg::TreeSlots];
  poa_pkg::stash_ent_t stash_mem [poa_pkg::StashDepth];
  poa_pkg::tree_ent_t  tree_rd_q;
  poa_pkg::stash_ent_t stash_rd_q;

  logic                               tree_we;
  logic [poa_pkg::TreeAddrBits-1:0]   tree_waddr;
  poa_pkg::tree_ent_t                 tree_wdata;
  logic                               stash_we;
  logic [poa_pkg::StashIdxBits-1:0]   stash_waddr;
  poa_pkg::stash_ent_t                stash_wdata;

  logic [poa_pkg::TreeAddrBits-1:0]   cur_path_addr, evict_addr;
  logic [poa_pkg::StashIdxBits-1:0]   free_idx;
  logic                               free_any;
  logic                               look_hit, take, path_match;
  logic [poa_pkg::TreeHeight-1:0]     leaf_diff;
  logic [poa_pkg::PayloadBits-1:0]    hit_data;

  assign cur_path_addr = path_addr(cur_q, cmd_i.level, cmd_i.slot);
  assign evict_addr    = path_addr(cur_q, cmd_i.level, used_q);

  // lowest free stash entry
  always_comb begin
    free_idx = '0;
    for (int i = poa_pkg::StashDepth - 1; i >= 0; i--) begin
      if (!sv_q[i]) free_idx = poa_pkg::StashIdxBits'(i);
    end
  end
  assign free_any = !(&sv_q);

  assign leaf_diff  = poa_pkg::TreeHeight'(stash_rd_q.leaf ^ cur_q) >> cmd_i.level;
  assign path_match = (leaf_diff == '0);
  assign take       = cmd_i.evict_chk && sv_q[cmd_i.chk_idx] && path_match &&
                      (used_q < poa_pkg::SlotCntBits'(poa_pkg::BucketSlots));
  assign look_hit   = cmd_i.look_chk && sv_q[cmd_i.chk_idx] && (stash_rd_q.id == id_q);
  assign hit_data   = wr_q ? wdata_q : stash_rd_q.data;

  always_comb begin
    tree_we    = 1'b0;
    tree_waddr = cur_path_addr;
    tree_wdata = '0;
    stash_we    = 1'b0;
    stash_waddr = free_idx;
    stash_wdata = '{id: tree_rd_q.id, leaf: tree_rd_q.leaf, data: tree_rd_q.data};
    sv_d   = sv_q;
    occ_d  = occ_q;
    need_d = need_q;
    used_d = used_q;
    found_d      = found_q;
    res_leaf_d   = res_leaf_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;

    if (out_valid_q && m_tready_i) out_valid_d = 1'b0;

    if (cmd_i.clr) begin
      tree_we    = 1'b1;
      tree_waddr = cmd_i.clr_addr;
    end

    if (cmd_i.start) begin
      need_d     = '0;
      found_d    = 1'b0;
      res_leaf_d = current_leaf_i & poa_pkg::LeafMask;
      res_data_d = '0;
    end

    if (cmd_i.path_count && tree_rd_q.valid) need_d = need_q + 1'b1;

    if (cmd_i.path_load && tree_rd_q.valid) begin
      tree_we        = 1'b1;
      stash_we       = 1'b1;
      sv_d[free_idx] = 1'b1;
      occ_d          = occ_q + 1'b1;
    end

    if (look_hit) begin
      stash_we    = 1'b1;
      stash_waddr = cmd_i.chk_idx;
      stash_wdata = '{id: id_q, leaf: fresh_q, data: hit_data};
      found_d     = 1'b1;
      res_leaf_d  = fresh_q;
      res_data_d  = hit_data;
    end

    if (cmd_i.insert) begin
      if (found_q) begin
        res_status_d = poa_pkg::ResHit;
      end else if (!wr_q) begin
        res_status_d = poa_pkg::ResReadMiss;
      end else if (free_any) begin
        res_status_d   = poa_pkg::ResInserted;
        res_leaf_d     = fresh_q;
        res_data_d     = wdata_q;
        stash_we       = 1'b1;
        stash_wdata    = '{id: id_q, leaf: fresh_q, data: wdata_q};
        sv_d[free_idx] = 1'b1;
        occ_d          = occ_q + 1'b1;
      end else begin
        res_status_d = poa_pkg::ResDropped;
        res_data_d   = wdata_q;
      end
    end

    if (take) begin
      tree_we    = 1'b1;
      tree_waddr = evict_addr;
      tree_wdata = '{valid: 1'b1, id: stash_rd_q.id, leaf: stash_rd_q.leaf,
                     data: stash_rd_q.data};
      sv_d[cmd_i.chk_idx] = 1'b0;
      occ_d  = occ_q - 1'b1;
      used_d = used_q + 1'b1;
    end

    // fill the rest of the bucket with null slots
    if (cmd_i.pad && (cmd_i.slot >= used_q)) tree_we = 1'b1;
    if (cmd_i.level_start) used_d = '0;

    if (cmd_i.abort) begin
      res_status_d = poa_pkg::ResOverflow;
      res_leaf_d   = cur_q;
      res_data_d   = '0;
      out_valid_d  = 1'b1;
    end
    if (cmd_i.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
    if (cmd_i.path_rd) tree_rd_q <= tree_mem[cur_path_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stash_we) stash_mem[stash_waddr] <= stash_wdata;
    if (cmd_i.stash_rd) stash_rd_q <= stash_mem[cmd_i.rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wr_q    <= action_i;
      id_q    <= req_id_i;
      cur_q   <= current_leaf_i & poa_pkg::LeafMask;
      fresh_q <= fresh_leaf_i & poa_pkg::LeafMask;
      wdata_q <= write_data_i[poa_pkg::PayloadBits-1:0];
    end
    res_leaf_q   <= res_leaf_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      occ_q       <= '0;
      need_q      <= '0;
      used_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sv_q        <= sv_d;
      occ_q       <= occ_d;
      need_q      <= need_d;
      used_q      <= used_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.fits = (poa_pkg::CmpBits'(need_q) + poa_pkg::CmpBits'(occ_q))
                       <= poa_pkg::CmpBits'(poa_pkg::StashDepth);
  assign stat_o.out_busy = out_valid_q;

  assign m_tvalid_o     = out_valid_q;
  assign out_req_id_o   = id_q;
  assign out_leaf_o     = res_leaf_q;
  assign out_data_o     = poa_pkg::DataBits'(res_data_q);
  assign status_o       = res_status_q;

endmodule

[rtl/core/path_oram_access_unit.sv]
// ---------------------------------------------------------------------------
// path_oram_access_unit - Path ORAM access engine
// Stream in one access request, get one result beat back.
// ---------------------------------------------------------------------------
// After reset the unit sweeps the bucket tree once, one slot per cycle
// (TreeSlots = 8192 slots), and takes no request until that is done. An
// access then runs alone: path count and path load each read the path slot
// by slot over the single-port tree memory, the stash lookup reads and checks
// each entry in turn, and eviction makes one pass over the stash per level
// followed by the bucket pad. An access aborted on stash overflow returns
// once the path count is done, without loading the path. The next request
// is taken once the result beat has been accepted.
module path_oram_access_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_id[9:0], current_leaf[19:10], fresh_leaf[29:20], write_data[93:30]
  input  logic [95:0] s_axis_tdata,
  // action[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_req_id[9:0], out_leaf[19:10], out_data[83:20]
  output logic [87:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);

  poa_pkg::dp_cmd_t  cmd;
  poa_pkg::dp_stat_t stat;

  logic [poa_pkg::IdBits-1:0]     out_req_id;
  logic [poa_pkg::LeafBits-1:0]   out_leaf;
  logic [poa_pkg::DataBits-1:0]   out_data;

  poa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  poa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (s_axis_tuser[0]),
    .req_id_i       (s_axis_tdata[9:0]),
    .current_leaf_i (s_axis_tdata[19:10]),
    .fresh_leaf_i   (s_axis_tdata[29:20]),
    .write_data_i   (s_axis_tdata[93:30]),
    .m_tready_i     (m_axis_tready),
    .m_tvalid_o     (m_axis_tvalid),
    .out_req_id_o   (out_req_id),
    .out_leaf_o     (out_leaf),
    .out_data_o     (out_data),
    .status_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, out_data, out_leaf, out_req_id};

endmodule

[tb/sv/path_oram_access_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// path_oram_access_unit_tb - self-checking bench of the Path ORAM access unit
// Streams read/write requests built from a tracked position map, with phases
// that crowd blocks onto a few leaves to force dropped inserts and stash
// overflow aborts. Results are checked against an in-bench model of the
// tree and stash, under random idling on both stream sides.
// ---------------------------------------------------------------------------
module path_oram_access_unit_tb;
  import poa_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam int RandItems  = 1050;
  localparam int CalmTail   = 100;

  typedef struct {
    logic                   wr;
    logic [IdBits-1:0]      id;
    logic [LeafBits-1:0]    cur;
    logic [LeafBits-1:0]    fresh;
    logic [DataBits-1:0]    wdata;
    bit                     drain_first;
  } access_t;

  typedef struct {
    logic [IdBits-1:0]   id;
    logic [LeafBits-1:0] leaf;
    logic [DataBits-1:0] data;
    res_status_e         status;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  path_oram_access_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  bit                   mt_valid [TreeSlots];
  logic [IdBits-1:0]    mt_id    [TreeSlots];
  logic [LeafBits-1:0]  mt_leaf  [TreeSlots];
  logic [DataBits-1:0]  mt_data  [TreeSlots];
  bit                   ms_valid [StashDepth];
  logic [IdBits-1:0]    ms_id    [StashDepth];
  logic [LeafBits-1:0]  ms_leaf  [StashDepth];
  logic [DataBits-1:0]  ms_data  [StashDepth];

  access_t pending_q[$];
  result_t expected_q[$];
  int      n_errors = 0;
  int      n_sent = 0;
  int      n_total = 0;
  int      n_results = 0;
  int      s_idle = 0;
  int      m_idle = 0;
  longint  cycles = 0;

  function automatic int bucket_of(logic [LeafBits-1:0] leaf, int up);
    return ((1 << TreeHeight) + int'(leaf & LeafMask)) >> up;
  endfunction

  function automatic result_t access_oram(access_t a);
    result_t r;
    int need, avail, nxt, base, t, used;
    bit found;
    logic [LeafBits-1:0] cur, fresh;
    need = 0; avail = 0; nxt = 0; found = 0;
    cur = a.cur & LeafMask;
    fresh = a.fresh & LeafMask;
    r.id = a.id; r.leaf = cur; r.data = '0;
    for (int up = 0; up <= TreeHeight; up++)
      for (int s = 0; s < BucketSlots; s++)
        if (mt_valid[bucket_of(cur, up) * BucketSlots + s]) need++;
    foreach (ms_valid[j]) if (!ms_valid[j]) avail++;
    if (need > avail) begin
      r.status = ResOverflow;
      return r;
    end
    for (int up = 0; up <= TreeHeight; up++)
      for (int s = 0; s < BucketSlots; s++) begin
        t = bucket_of(cur, up) * BucketSlots + s;
        if (mt_valid[t]) begin
          while (nxt < StashDepth && ms_valid[nxt]) nxt++;
          if (nxt < StashDepth) begin
            ms_valid[nxt] = 1; ms_id[nxt] = mt_id[t];
            ms_leaf[nxt] = mt_leaf[t]; ms_data[nxt] = mt_data[t];
            mt_valid[t] = 0;
          end
        end
      end
    // every duplicate is remapped; the last one reports
    foreach (ms_valid[j])
      if (ms_valid[j] && ms_id[j] == a.id) begin
        found = 1;
        if (a.wr) ms_data[j] = a.wdata;
        ms_leaf[j] = fresh;
        r.leaf = fresh;
        r.data = ms_data[j];
      end
    if (found) r.status = ResHit;
    else if (!a.wr) r.status = ResReadMiss;
    else begin
      r.status = ResDropped;
      r.data = a.wdata;
      for (int j = 0; j < StashDepth; j++)
        if (!ms_valid[j]) begin
          ms_valid[j] = 1; ms_id[j] = a.id; ms_leaf[j] = fresh; ms_data[j] = a.wdata;
          r.leaf = fresh;
          r.status = ResInserted;
          break;
        end
    end
    for (int up = 0; up <= TreeHeight; up++) begin
      base = bucket_of(cur, up) * BucketSlots;
      used = 0;
      for (int j = 0; j < StashDepth && used < BucketSlots; j++)
        if (ms_valid[j] && bucket_of(ms_leaf[j], up) == bucket_of(cur, up)) begin
          mt_valid[base+used] = 1; mt_id[base+used] = ms_id[j];
          mt_leaf[base+used] = ms_leaf[j]; mt_data[base+used] = ms_data[j];
          ms_valid[j] = 0;
          used++;
        end
      for (int s = used; s < BucketSlots; s++) mt_valid[base+s] = 0;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    access_t a;
    logic    v;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      v = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.insert(expected_q.size(), access_oram(pending_q.pop_front()));
        n_sent++;
        v = 1'b0;
      end
      if (!v) begin
        if (s_idle > 0) begin
          s_idle--;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && expected_q.size() != 0)) begin
          a = pending_q[0];
          s_axis_tdata <= {2'b00, a.wdata, a.fresh, a.cur, a.id};
          s_axis_tuser <= a.wr;
          v = 1'b1;
          if (n_sent < n_total - CalmTail && $urandom_range(0, 3) == 0)
            s_idle = $urandom_range(1, 17);
        end
      end
      s_axis_tvalid <= v;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          n_errors++;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tdata[9:0] !== e.id) begin
            $error("out_req_id: expected %0d, got %0d", e.id, m_axis_tdata[9:0]);
            n_errors++;
          end
          if (m_axis_tdata[19:10] !== e.leaf) begin
            $error("out_leaf: expected %0d, got %0d", e.leaf, m_axis_tdata[19:10]);
            n_errors++;
          end
          if (m_axis_tdata[83:20] !== e.data) begin
            $error("out_data: expected %h, got %h", e.data, m_axis_tdata[83:20]);
            n_errors++;
          end
          if (m_axis_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
            n_errors++;
          end
        end
      end
      if (m_idle > 0) begin
        m_idle--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (n_results < n_total - CalmTail && $urandom_range(0, 3) == 0)
          m_idle = $urandom_range(1, 17);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_access(logic wr, int id, int cur, int fresh, logic [63:0] d,
                            bit drain = 0);
    access_t a;
    a.wr = wr; a.id = id; a.cur = cur; a.fresh = fresh; a.wdata = d;
    a.drain_first = drain;
    pending_q.insert(pending_q.size(), a);
    n_total++;
  endtask

  initial begin
    logic [LeafBits-1:0] pos [1024];
    int id, cur, fresh, r;
    foreach (pos[i]) pos[i] = $urandom_range(0, 1023);

    // directed
    add_access(0, 0, 0, 0, '0);                                  // read miss
    add_access(1, 1023, 1023, 1023, '1);                         // insert
    add_access(0, 1023, 1023, 0, 64'h0);                         // read hit, remap
    add_access(1, 1023, 0, 512, 64'h0);                          // write hit
    add_access(0, 1023, 3, 3, 64'hffff);                         // stale leaf, but the root holds it: read hit
    add_access(1, 1023, 3, 7, 64'h5555_aaaa_5555_aaaa);          // write hit, remap to leaf 7
    add_access(0, 1023, 512, 7, '0);                             // block is off this path: read miss
    add_access(1, 0, 0, 1023, 64'h8000_0000_0000_0001, 1);
    add_access(0, 0, 1023, 1023, '0);
    add_access(1, 682, 341, 682, 64'haaaa_5555_aaaa_5555);
    add_access(0, 682, 682, 341, '0);
    add_access(0, 341, 341, 0, '1);
    for (int k = 0; k < 12; k++)                                 // crowd leaf 0
      add_access(1, 100 + k, 0, 0, {$urandom, $urandom});

    for (int k = 0; k < RandItems; k++) begin
      r = $urandom_range(0, 99);
      id = (r < 85) ? $urandom_range(0, 95) : $urandom_range(0, 1023);
      // middle phase piles blocks onto a few leaves to fill the stash
      if (k > 250 && k < 650) fresh = $urandom_range(0, 3);
      else fresh = $urandom_range(0, 1023);
      cur = (r < 80 || r >= 95) ? pos[id] : $urandom_range(0, 1023);
      if (r < 80 || r >= 95) pos[id] = fresh;
      add_access($urandom_range(0, 1), id, cur, fresh, {$urandom, $urandom},
                 k == RandItems / 2);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (700) @(posedge clk_i);
    if (n_errors == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
